FILE: hdl/hvn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hvn_pkg;

   // grid geometry
   localparam int MAX_SIDE    = 64;
   localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int SIDE_W      = 7;
   localparam int INDEX_W     = 12;
   localparam int QSIZE_W     = 12;
   localparam int HEIGHT_W    = 16;
   localparam int NORM_W      = 16;
   localparam int CSR_AW      = 2;
   localparam int CSR_DW      = 12;

   // shared multiplier operand and product widths
   localparam int MUL_W  = 32;
   localparam int PROD_W = 2 * MUL_W;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_VERTS_PER_SIDE = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_QUAD_SIZE      = 2'd1;

   // reset values of the registers
   localparam logic [SIDE_W-1:0]  VERTS_RESET = 7'd64;
   localparam logic [QSIZE_W-1:0] QSIZE_RESET = 12'd100;

   // unit z in Q1.15, saturated
   localparam logic signed [NORM_W-1:0] NORM_ONE = 16'sd32767;

   typedef struct packed {
      logic                        req_type;
      logic [INDEX_W-1:0]          vertex_index;
      logic signed [HEIGHT_W-1:0]  height;
   } hvn_req_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] normal_x;
      logic signed [NORM_W-1:0] normal_y;
      logic signed [NORM_W-1:0] normal_z;
      logic                     on_edge;
   } hvn_rsp_type;

   // height store port request
   typedef struct packed {
      logic                        wr_en;
      logic [STORE_AW-1:0]         wr_addr;
      logic signed [HEIGHT_W-1:0]  wr_data;
      logic [STORE_AW-1:0]         rd_addr;
   } hvn_st_req_type;

endpackage

`default_nettype wire

FILE: hdl/hvn_store.sv
`timescale 1ns / 1ps
`default_nettype none

module hvn_store (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire hvn_pkg::hvn_st_req_type             st_req,
   output logic signed [hvn_pkg::HEIGHT_W-1:0]      rd_data,
   output logic                                     clearing
);
   import hvn_pkg::*;

   logic signed [HEIGHT_W-1:0] mem [STORE_DEPTH];
   logic signed [HEIGHT_W-1:0] rd_data_ff;
   logic                       clr_ff, clr_in;
   logic [STORE_AW-1:0]        clr_addr_ff, clr_addr_in;
   logic                       wr_en;
   logic [STORE_AW-1:0]        wr_addr;
   logic signed [HEIGHT_W-1:0] wr_data;

   // clearing pass after reset, one entry a cycle
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == STORE_AW'(STORE_DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // write port shared by the clearing pass and height writes
   always_comb begin
      if (clr_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = st_req.wr_en;
         wr_addr = st_req.wr_addr;
         wr_data = st_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[st_req.rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_ff;

endmodule

`default_nettype wire

FILE: hdl/hvn_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module hvn_mul (
   input  wire logic                          clock,
   input  wire logic [hvn_pkg::MUL_W-1:0]     opa,
   input  wire logic [hvn_pkg::MUL_W-1:0]     opb,
   output logic [hvn_pkg::PROD_W-1:0]         prod
);
   import hvn_pkg::*;

   logic [PROD_W-1:0] prod_ff;

   // registered unsigned product
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(opa) * PROD_W'(opb);
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

FILE: hdl/hvn_core.sv
`timescale 1ns / 1ps
`default_nettype none

module hvn_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_acc,
   input  wire hvn_pkg::hvn_req_type                req_word,
   input  wire logic [hvn_pkg::SIDE_W-1:0]          side,
   input  wire logic [hvn_pkg::QSIZE_W-1:0]         qsize,
   output hvn_pkg::hvn_st_req_type                  st_req,
   input  wire logic signed [hvn_pkg::HEIGHT_W-1:0] rd_data,
   output logic [hvn_pkg::MUL_W-1:0]                mul_opa,
   output logic [hvn_pkg::MUL_W-1:0]                mul_opb,
   input  wire logic [hvn_pkg::PROD_W-1:0]          mul_prod,
   output logic                                     rsp_strobe,
   output hvn_pkg::hvn_rsp_type                     rsp_word,
   output logic                                     core_busy
);
   import hvn_pkg::*;

   localparam int CNT_W     = 4;
   localparam int DIV_LAST  = INDEX_W - 1;
   localparam int MAG_W     = 16;
   localparam int N_W       = 15;
   localparam int S_W       = 34;
   localparam int S_LO_W    = 17;
   localparam int TSQ_W     = 2 * N_W;
   localparam int LO_W      = TSQ_W + S_LO_W;
   localparam int RHS_SHIFT = 30;
   localparam int RHS_W     = 2 * MAG_W + RHS_SHIFT;
   localparam int TOTAL_W   = 2 * SIDE_W;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_DIV  = 7'b0000010,
      ST_CHK  = 7'b0000100,
      ST_RD   = 7'b0001000,
      ST_SQ   = 7'b0010000,
      ST_MAG  = 7'b0100000,
      ST_SRCH = 7'b1000000
   } state_type;

   state_type                   state_ff, state_in;
   logic [INDEX_W-1:0]          idx_ff, idx_in;
   logic [INDEX_W-1:0]          dvd_ff, dvd_in;
   logic [INDEX_W-1:0]          quo_ff, quo_in;
   logic [SIDE_W-1:0]           rem_ff, rem_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [1:0]                  ph_ff, ph_in;
   logic [1:0]                  comp_ff, comp_in;
   logic signed [HEIGHT_W-1:0]  hgt_ff [4];
   logic signed [HEIGHT_W-1:0]  hgt_in [4];
   logic [S_W-1:0]              s_ff, s_in;
   logic [RHS_W-1:0]            rhs_ff, rhs_in;
   logic [N_W-1:0]              n_ff, n_in;
   logic [TSQ_W-1:0]            tsq_ff, tsq_in;
   logic [LO_W-1:0]             lo_ff, lo_in;
   hvn_rsp_type                 res_ff, res_in;
   logic                        strobe_ff, strobe_in;

   logic [TOTAL_W-1:0]          total;
   logic                        in_range;
   logic [SIDE_W:0]             trial;
   logic                        trial_ge;
   logic [SIDE_W:0]             trial_sub;
   logic [SIDE_W-1:0]           side_m1;
   logic                        on_border;
   logic signed [HEIGHT_W:0]    a_val, b_val, a_neg, b_neg;
   logic [MAG_W-1:0]            abs_a, abs_b, c_val, mag;
   logic                        neg;
   logic [N_W-1:0]              t_val, n_new;
   logic [PROD_W-1:0]           prod_sum;
   logic                        fits;
   logic [S_W-1:0]              s_sum;
   logic signed [NORM_W-1:0]    sres;

   // range check against side squared
   assign total    = TOTAL_W'(side) * TOTAL_W'(side);
   assign in_range = (side != '0) &&
                     (TOTAL_W'(req_word.vertex_index) < total);

   // one restoring divide step
   assign trial     = {rem_ff, dvd_ff[INDEX_W-1]};
   assign trial_ge  = trial >= {1'b0, side};
   assign trial_sub = trial - {1'b0, side};

   // border test on row and column
   assign side_m1   = side - 1'b1;
   assign on_border = (quo_ff == '0) || (rem_ff == '0) ||
                      (quo_ff == INDEX_W'(side_m1)) || (rem_ff == side_m1);

   // central differences and their magnitudes
   assign a_val = (HEIGHT_W+1)'(hgt_ff[0]) - (HEIGHT_W+1)'(hgt_ff[1]);
   assign b_val = (HEIGHT_W+1)'(hgt_ff[2]) - (HEIGHT_W+1)'(hgt_ff[3]);
   assign a_neg = -a_val;
   assign b_neg = -b_val;
   assign abs_a = a_val[HEIGHT_W] ? a_neg[MAG_W-1:0] : a_val[MAG_W-1:0];
   assign abs_b = b_val[HEIGHT_W] ? b_neg[MAG_W-1:0] : b_val[MAG_W-1:0];
   assign c_val = MAG_W'({qsize, 1'b0});

   // component being scaled: x from -a, y from -b, z from 2q
   always_comb begin
      case (comp_ff)
         2'd0: begin
            mag = abs_a;
            neg = !a_val[HEIGHT_W];
         end
         2'd1: begin
            mag = abs_b;
            neg = !b_val[HEIGHT_W];
         end
         default: begin
            mag = c_val;
            neg = 1'b0;
         end
      endcase
   end

   // bit search: keep the trial bit when t^2 * s <= mag^2 * 2^30
   assign t_val    = n_ff | (N_W'(1) << cnt_ff);
   assign prod_sum = {mul_prod[LO_W-1:0], {S_LO_W{1'b0}}} + PROD_W'(lo_ff);
   assign fits     = prod_sum <= PROD_W'(rhs_ff);
   assign n_new    = fits ? t_val : n_ff;
   assign sres     = neg ? (NORM_W'(0) - NORM_W'(n_new)) : NORM_W'(n_new);
   assign s_sum    = s_ff + mul_prod[S_W-1:0];

   // multiplier operand select
   always_comb begin
      mul_opa = '0;
      mul_opb = '0;
      unique case (state_ff)
         ST_SQ: begin
            case (cnt_ff)
               4'd0: begin
                  mul_opa = MUL_W'(abs_a);
                  mul_opb = MUL_W'(abs_a);
               end
               4'd1: begin
                  mul_opa = MUL_W'(abs_b);
                  mul_opb = MUL_W'(abs_b);
               end
               4'd2: begin
                  mul_opa = MUL_W'(c_val);
                  mul_opb = MUL_W'(c_val);
               end
               default: begin
                  mul_opa = '0;
                  mul_opb = '0;
               end
            endcase
         end
         ST_MAG: begin
            mul_opa = MUL_W'(mag);
            mul_opb = MUL_W'(mag);
         end
         ST_SRCH: begin
            case (ph_ff)
               2'd0: begin
                  mul_opa = MUL_W'(t_val);
                  mul_opb = MUL_W'(t_val);
               end
               2'd1: begin
                  mul_opa = MUL_W'(mul_prod[TSQ_W-1:0]);
                  mul_opb = MUL_W'(s_ff[S_LO_W-1:0]);
               end
               2'd2: begin
                  mul_opa = MUL_W'(tsq_ff);
                  mul_opb = MUL_W'(s_ff[S_W-1:S_LO_W]);
               end
               default: begin
                  mul_opa = '0;
                  mul_opb = '0;
               end
            endcase
         end
         default: begin
            mul_opa = '0;
            mul_opb = '0;
         end
      endcase
   end

   // height store requests
   always_comb begin
      st_req.wr_en   = req_acc && (req_word.req_type == REQ_WRITE) && in_range;
      st_req.wr_addr = STORE_AW'(req_word.vertex_index);
      st_req.wr_data = req_word.height;
      case (cnt_ff)
         4'd0:    st_req.rd_addr = STORE_AW'(idx_ff + INDEX_W'(side));
         4'd1:    st_req.rd_addr = STORE_AW'(idx_ff - INDEX_W'(side));
         4'd2:    st_req.rd_addr = STORE_AW'(idx_ff + 1'b1);
         default: st_req.rd_addr = STORE_AW'(idx_ff - 1'b1);
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      dvd_in    = dvd_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      ph_in     = ph_ff;
      comp_in   = comp_ff;
      hgt_in    = hgt_ff;
      s_in      = s_ff;
      rhs_in    = rhs_ff;
      n_in      = n_ff;
      tsq_in    = tsq_ff;
      lo_in     = lo_ff;
      res_in    = res_ff;
      strobe_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_word.req_type == REQ_QUERY)) begin
               idx_in = req_word.vertex_index;
               if (!in_range) begin
                  res_in    = '{normal_x: '0, normal_y: '0, normal_z: NORM_ONE, on_edge: 1'b1};
                  strobe_in = 1'b1;
               end else begin
                  dvd_in   = req_word.vertex_index;
                  quo_in   = '0;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in = trial_ge ? trial_sub[SIDE_W-1:0] : trial[SIDE_W-1:0];
            quo_in = {quo_ff[INDEX_W-2:0], trial_ge};
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_LAST)) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (on_border) begin
               res_in    = '{normal_x: '0, normal_y: '0, normal_z: NORM_ONE, on_edge: 1'b1};
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cnt_in   = '0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            if (cnt_ff != '0) begin
               hgt_in[2'(cnt_ff - 1'b1)] = rd_data;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd4) begin
               cnt_in   = '0;
               s_in     = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (cnt_ff != '0) begin
               s_in = s_sum;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'd3) begin
               if (s_sum == '0) begin
                  // flat with zero quad size: no direction
                  res_in    = '{normal_x: '0, normal_y: '0, normal_z: '0, on_edge: 1'b0};
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  comp_in  = '0;
                  ph_in    = '0;
                  state_in = ST_MAG;
               end
            end
         end
         ST_MAG: begin
            if (ph_ff == '0) begin
               ph_in = 2'd1;
            end else begin
               rhs_in   = {mul_prod[2*MAG_W-1:0], {RHS_SHIFT{1'b0}}};
               n_in     = '0;
               cnt_in   = CNT_W'(N_W - 1);
               ph_in    = '0;
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            case (ph_ff)
               2'd0: ph_in = 2'd1;
               2'd1: begin
                  tsq_in = mul_prod[TSQ_W-1:0];
                  ph_in  = 2'd2;
               end
               2'd2: begin
                  lo_in = mul_prod[LO_W-1:0];
                  ph_in = 2'd3;
               end
               default: begin
                  n_in  = n_new;
                  ph_in = '0;
                  if (cnt_ff == '0) begin
                     case (comp_ff)
                        2'd0:    res_in.normal_x = sres;
                        2'd1:    res_in.normal_y = sres;
                        default: res_in.normal_z = sres;
                     endcase
                     if (comp_ff == 2'd2) begin
                        res_in.on_edge = 1'b0;
                        strobe_in      = 1'b1;
                        state_in       = ST_IDLE;
                     end else begin
                        comp_in  = comp_ff + 1'b1;
                        state_in = ST_MAG;
                     end
                  end else begin
                     cnt_in = cnt_ff - 1'b1;
                  end
               end
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      ph_ff   <= ph_in;
      comp_ff <= comp_in;
      hgt_ff  <= hgt_in;
      s_ff    <= s_in;
      rhs_ff  <= rhs_in;
      n_ff    <= n_in;
      tsq_ff  <= tsq_in;
      lo_ff   <= lo_in;
      res_ff  <= res_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = res_ff;
   assign core_busy  = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

FILE: hdl/heightmap_vertex_normal.sv
`timescale 1ns / 1ps
`default_nettype none

// Heightmap vertex normal unit: keeps a 64 x 64 grid of signed heights and
// returns the unit normal (Q1.15) at a vertex from central differences.
// Request channel: drive req_word and raise start; the word is taken at a
// clock edge where start is high and busy is low. A height write inside the grid
// is stored at that edge and gives no response. A query gives one response word on
// rsp_word, shown for exactly one cycle while rsp_strobe is high; the
// receiver cannot stall it, so it must take the word in that cycle.
// A query with an index outside the grid is answered in the next cycle, a
// border vertex after the divide and border check, and an interior vertex
// after the full normal computation. busy stays high while a query is worked
// on, so queries run one at a time; a height write leaves busy low. An
// interior query runs a 12-step divide for row and column, four store reads,
// three squares on the shared 32 x 32 multiplier, then a 15-bit search per
// normal component on the same multiplier.
// Registers (csr_index, csr_wdata, csr_valid; csr_ready is always high):
// verts_per_side and quad_size, to be written while busy is low.
// Reset: registers return to 64 and 100, and a clearing pass zeroes the
// whole height store, with busy high until it ends.
module heightmap_vertex_normal (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire hvn_pkg::hvn_req_type           req_word,
   output logic                                rsp_strobe,
   output hvn_pkg::hvn_rsp_type                rsp_word,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [hvn_pkg::CSR_AW-1:0]     csr_index,
   input  wire logic [hvn_pkg::CSR_DW-1:0]     csr_wdata
);
   import hvn_pkg::*;

   logic [SIDE_W-1:0]          verts_ff, verts_in;
   logic [QSIZE_W-1:0]         qsize_ff, qsize_in;
   logic [SIDE_W-1:0]          side_eff;
   logic                       req_acc;
   logic                       clearing;
   logic                       core_busy;
   hvn_st_req_type             st_req;
   logic signed [HEIGHT_W-1:0] rd_data;
   logic [MUL_W-1:0]           mul_opa, mul_opb;
   logic [PROD_W-1:0]          mul_prod;

   // register writes
   always_comb begin
      verts_in = verts_ff;
      qsize_in = qsize_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VERTS_PER_SIDE: verts_in = csr_wdata[SIDE_W-1:0];
            CSR_QUAD_SIZE:      qsize_in = csr_wdata[QSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         verts_ff <= VERTS_RESET;
         qsize_ff <= QSIZE_RESET;
      end else begin
         verts_ff <= verts_in;
         qsize_ff <= qsize_in;
      end
   end

   // side clamped to the grid size
   assign side_eff = (verts_ff > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : verts_ff;

   assign csr_ready = 1'b1;
   assign busy      = clearing || core_busy;
   assign req_acc   = start && !busy;

   hvn_store u_store (
      .clock    (clock),
      .reset    (reset),
      .st_req   (st_req),
      .rd_data  (rd_data),
      .clearing (clearing)
   );

   hvn_mul u_mul (
      .clock (clock),
      .opa   (mul_opa),
      .opb   (mul_opb),
      .prod  (mul_prod)
   );

   hvn_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_acc    (req_acc),
      .req_word   (req_word),
      .side       (side_eff),
      .qsize      (qsize_ff),
      .st_req     (st_req),
      .rd_data    (rd_data),
      .mul_opa    (mul_opa),
      .mul_opb    (mul_opb),
      .mul_prod   (mul_prod),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .core_busy  (core_busy)
   );

endmodule

`default_nettype wire

FILE: hdl/hvn_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hvn_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire hvn_pkg::hvn_req_type        req_word,
   input wire logic                        rsp_strobe,
   input wire hvn_pkg::hvn_rsp_type        rsp_word
);
   import hvn_pkg::*;

   // reset starts the clearing pass, so no word is taken right after it
   a_reset_busy: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low after reset");

   // a height write never produces a response word
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.req_type == REQ_WRITE)) |=> !rsp_strobe)
      else $error("response after a height write");

   // border and out-of-range vertices answer straight up
   a_edge_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.on_edge) |->
         (rsp_word.normal_x == '0) && (rsp_word.normal_y == '0) &&
         (rsp_word.normal_z == NORM_ONE))
      else $error("edge response is not unit z");

   // z comes from twice the quad size and is never negative
   a_z_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !rsp_word.normal_z[NORM_W-1])
      else $error("negative normal z");

endmodule

bind heightmap_vertex_normal hvn_checker u_hvn_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_word   (req_word),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);

`default_nettype wire
